[hdl/bftv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arctangent table for the body frame target velocity block.
// No dependencies; every other file of the block imports this package.
package bftv_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;

    localparam int HEADING_W  = 16;
    localparam int OUT_W      = 16;
    localparam int RADIUS_W   = 15;
    localparam int GAIN_W     = 8;
    localparam int SPEED_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // world command width: holds +-2^26 and the far speed
    localparam int VEC_W     = 28;
    // rotation datapath width
    localparam int ROT_W     = 46;
    localparam int NEAR_LIMIT = 1 << 26;
    localparam logic signed [31:0] INV_K_Q30 = 32'sd652032874;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd10;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd30;
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 12'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_RADIUS = 2'd0,
        REG_NEAR_GAIN   = 2'd1,
        REG_MAX_SPEED   = 2'd2
    } cfg_reg_t;

    function automatic int step_count(input int steps);
        return (steps < MAX_STEPS) ? steps : MAX_STEPS;
    endfunction

    // atan(2^-i) as a 32-bit fraction of a turn
    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] e;
        case (i)
            0:  e = 32'h20000000;
            1:  e = 32'h12E4051E;
            2:  e = 32'h09FB385B;
            3:  e = 32'h051111D4;
            4:  e = 32'h028B0D43;
            5:  e = 32'h0145D7E1;
            6:  e = 32'h00A2F61E;
            7:  e = 32'h00517C55;
            8:  e = 32'h0028BE53;
            9:  e = 32'h00145F2F;
            10: e = 32'h000A2F98;
            11: e = 32'h000517CC;
            12: e = 32'h00028BE6;
            13: e = 32'h000145F3;
            14: e = 32'h0000A2FA;
            15: e = 32'h0000517D;
            16: e = 32'h000028BE;
            17: e = 32'h0000145F;
            18: e = 32'h00000A30;
            19: e = 32'h00000518;
            20: e = 32'h0000028C;
            21: e = 32'h00000146;
            22: e = 32'h000000A3;
            default: e = 32'h00000051;
        endcase
        return e;
    endfunction

    // table entry rounded half up to an angle of aw bits
    function automatic logic [31:0] atan_step(input int i, input int aw);
        logic [32:0] e;
        e = {1'b0, atan_turn32(i)} + (33'd1 << (31 - aw));
        return e[32:1] >> (31 - aw);
    endfunction

endpackage

[hdl/bftv_front.sv]
`timescale 1ns / 1ps
// Front pipeline: offset, near test, gain and vectoring CORDIC for the bearing.
// Depends on bftv_pkg.
module bftv_front
    import bftv_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] robot_x,
    input  logic signed [COORD_WIDTH-1:0] robot_y,
    input  logic signed [COORD_WIDTH-1:0] goal_x,
    input  logic signed [COORD_WIDTH-1:0] goal_y,
    input  logic        [HEADING_W-1:0]   heading,
    input  logic        [RADIUS_W-1:0]    near_radius,
    input  logic        [GAIN_W-1:0]      near_gain,
    input  logic        [SPEED_W-1:0]     max_speed,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VEC_W-1:0]       out_vx,
    output logic signed [VEC_W-1:0]       out_vy,
    output logic        [ANGLE_WIDTH-1:0] out_phi,
    output logic                          out_near
);

    localparam int N   = step_count(CORDIC_STEPS);
    localparam int AW  = ANGLE_WIDTH;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int VW  = COORD_WIDTH + 18;
    localparam int MW  = (DW > RADIUS_W) ? DW : RADIUS_W;
    localparam int PW  = DW + GAIN_W + 1;
    localparam int CPW = (PW > VEC_W) ? PW : VEC_W;
    localparam logic signed [CPW-1:0] LIM = CPW'(NEAR_LIMIT);
    localparam logic [AW-1:0] HALF = {1'b1, {(AW-1){1'b0}}};

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---- stage 1: offset, box test, heading conversion
    logic signed [DW-1:0] dx_next, dy_next;
    logic [DW-1:0]        adx_full, ady_full;
    logic [MW-1:0]        adx_m, ady_m;
    logic [23:0]          h24;

    assign dx_next  = DW'(goal_x) - DW'(robot_x);
    assign dy_next  = DW'(goal_y) - DW'(robot_y);
    assign adx_full = dx_next[DW-1] ? $unsigned(-dx_next) : $unsigned(dx_next);
    assign ady_full = dy_next[DW-1] ? $unsigned(-dy_next) : $unsigned(dy_next);
    assign adx_m    = MW'(adx_full);
    assign ady_m    = MW'(ady_full);
    assign h24      = {heading, 8'd0};

    logic                 f1_vld_reg;
    logic signed [DW-1:0] f1_dx_reg, f1_dy_reg;
    logic [RADIUS_W-1:0]  f1_adx_reg, f1_ady_reg;
    logic                 f1_box_reg;
    logic [AW-1:0]        f1_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= in_valid;
        end
        if (en) begin
            f1_dx_reg  <= dx_next;
            f1_dy_reg  <= dy_next;
            f1_adx_reg <= adx_m[RADIUS_W-1:0];
            f1_ady_reg <= ady_m[RADIUS_W-1:0];
            f1_box_reg <= (adx_m <= MW'(near_radius)) && (ady_m <= MW'(near_radius));
            f1_h_reg   <= h24[23 -: AW];
        end
    end

    // ---- stage 2: squares, gain product, vectoring start
    logic [30:0]           sq_next;
    logic [29:0]           r2_next;
    logic signed [CPW-1:0] gx, gy, gx_c, gy_c, gain_s;
    logic signed [VW-1:0]  x0, y0;

    assign sq_next = 31'(f1_adx_reg) * 31'(f1_adx_reg) + 31'(f1_ady_reg) * 31'(f1_ady_reg);
    assign r2_next = 30'(near_radius) * 30'(near_radius);
    assign gain_s  = CPW'($signed({1'b0, near_gain}));
    assign gx      = gain_s * CPW'(f1_dx_reg);
    assign gy      = gain_s * CPW'(f1_dy_reg);
    assign gx_c    = (gx > LIM) ? LIM : ((gx < -LIM) ? -LIM : gx);
    assign gy_c    = (gy > LIM) ? LIM : ((gy < -LIM) ? -LIM : gy);
    assign x0      = VW'(f1_dx_reg) <<< 14;
    assign y0      = VW'(f1_dy_reg) <<< 14;

    logic                    f2_vld_reg;
    logic [30:0]             f2_sq_reg;
    logic [29:0]             f2_r2_reg;
    logic                    f2_box_reg;
    logic signed [VEC_W-1:0] f2_wx_reg, f2_wy_reg;
    logic signed [VW-1:0]    f2_x_reg, f2_y_reg;
    logic [AW-1:0]           f2_z_reg, f2_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
        if (en) begin
            f2_sq_reg  <= sq_next;
            f2_r2_reg  <= r2_next;
            f2_box_reg <= f1_box_reg;
            f2_wx_reg  <= VEC_W'(gx_c);
            f2_wy_reg  <= VEC_W'(gy_c);
            // fold the left half plane onto the right one
            f2_x_reg   <= f1_dx_reg[DW-1] ? -x0 : x0;
            f2_y_reg   <= f1_dx_reg[DW-1] ? -y0 : y0;
            f2_z_reg   <= f1_dx_reg[DW-1] ? HALF : '0;
            f2_h_reg   <= f1_h_reg;
        end
    end

    logic near_next;
    assign near_next = f2_box_reg && (f2_sq_reg <= 31'(f2_r2_reg));

    // ---- vectoring CORDIC, one micro-rotation per stage
    logic                    v_vld_reg  [N];
    logic signed [VW-1:0]    v_x_reg    [N];
    logic signed [VW-1:0]    v_y_reg    [N];
    logic [AW-1:0]           v_z_reg    [N];
    logic [AW-1:0]           v_h_reg    [N];
    logic                    v_near_reg [N];
    logic signed [VEC_W-1:0] v_wx_reg   [N];
    logic signed [VEC_W-1:0] v_wy_reg   [N];

    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic [31:0] ATAN_FULL = atan_step(i, AW);
        logic                    vld_in, near_in;
        logic signed [VW-1:0]    x_in, y_in, x_next, y_next;
        logic [AW-1:0]           z_in, h_in, z_next;
        logic signed [VEC_W-1:0] wx_in, wy_in;

        if (i == 0) begin : g_first
            assign vld_in  = f2_vld_reg;
            assign near_in = near_next;
            assign x_in    = f2_x_reg;
            assign y_in    = f2_y_reg;
            assign z_in    = f2_z_reg;
            assign h_in    = f2_h_reg;
            assign wx_in   = f2_wx_reg;
            assign wy_in   = f2_wy_reg;
        end else begin : g_next
            assign vld_in  = v_vld_reg[i-1];
            assign near_in = v_near_reg[i-1];
            assign x_in    = v_x_reg[i-1];
            assign y_in    = v_y_reg[i-1];
            assign z_in    = v_z_reg[i-1];
            assign h_in    = v_h_reg[i-1];
            assign wx_in   = v_wx_reg[i-1];
            assign wy_in   = v_wy_reg[i-1];
        end

        // drive y toward zero
        always_comb begin
            if (!y_in[VW-1]) begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + ATAN_FULL[AW-1:0];
            end else begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - ATAN_FULL[AW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_vld_reg[i] <= 1'b0;
            end else if (en) begin
                v_vld_reg[i] <= vld_in;
            end
            if (en) begin
                v_x_reg[i]    <= x_next;
                v_y_reg[i]    <= y_next;
                v_z_reg[i]    <= z_next;
                v_h_reg[i]    <= h_in;
                v_near_reg[i] <= near_in;
                v_wx_reg[i]   <= wx_in;
                v_wy_reg[i]   <= wy_in;
            end
        end
    end

    // ---- pick the world command and the rotation angle
    assign out_valid = v_vld_reg[N-1];
    assign out_near  = v_near_reg[N-1];
    assign out_vx    = v_near_reg[N-1] ? v_wx_reg[N-1] : VEC_W'($signed({1'b0, max_speed}));
    assign out_vy    = v_near_reg[N-1] ? v_wy_reg[N-1] : '0;
    assign out_phi   = v_near_reg[N-1] ? (AW'(0) - v_h_reg[N-1])
                                       : (v_z_reg[N-1] - v_h_reg[N-1]);

endmodule

[hdl/bftv_queue.sv]
`timescale 1ns / 1ps
// Short register queue between the front and back pipelines.
// Depends on bftv_pkg, which supplies the default of WIDTH.
module bftv_queue
    import bftv_pkg::*;
#(
    parameter int WIDTH = 2 * VEC_W + ANGLE_WIDTH_DEF + 1,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/bftv_back.sv]
`timescale 1ns / 1ps
// Back pipeline: quadrant fold, gain compensation, rotation CORDIC, round and saturate.
// Depends on bftv_pkg.
module bftv_back
    import bftv_pkg::*;
#(
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VEC_W-1:0]       in_vx,
    input  logic signed [VEC_W-1:0]       in_vy,
    input  logic        [ANGLE_WIDTH-1:0] in_phi,
    input  logic                          in_near,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_W-1:0]       out_lat,
    output logic signed [OUT_W-1:0]       out_fwd,
    output logic                          out_near
);

    localparam int N    = step_count(CORDIC_STEPS);
    localparam int AW   = ANGLE_WIDTH;
    localparam int MULW = VEC_W + 32;
    localparam int QW   = ROT_W - 16;
    localparam logic signed [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};
    localparam logic [AW-1:0]        HALF    = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [QW-1:0] SAT_HI  = QW'(32767);
    localparam logic signed [QW-1:0] SAT_LO  = -QW'(32768);

    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // ---- fold the angle into +-quarter turn
    logic signed [AW-1:0] z_in;
    logic                 flip;
    assign z_in = $signed(in_phi);
    assign flip = (z_in > QUARTER) || (z_in < -QUARTER);

    logic                    b0_vld_reg, b0_near_reg;
    logic signed [VEC_W-1:0] b0_vx_reg, b0_vy_reg;
    logic [AW-1:0]           b0_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_vld_reg <= 1'b0;
        end else if (en) begin
            b0_vld_reg <= in_valid;
        end
        if (en) begin
            b0_near_reg <= in_near;
            b0_vx_reg   <= flip ? -in_vx : in_vx;
            b0_vy_reg   <= flip ? -in_vy : in_vy;
            b0_z_reg    <= flip ? (in_phi + HALF) : in_phi;
        end
    end

    // ---- scale by 1/K
    logic signed [MULW-1:0] mx, my;
    assign mx = MULW'(b0_vx_reg) * MULW'(INV_K_Q30);
    assign my = MULW'(b0_vy_reg) * MULW'(INV_K_Q30);

    logic                    b1_vld_reg, b1_near_reg;
    logic signed [ROT_W-1:0] b1_x_reg, b1_y_reg;
    logic [AW-1:0]           b1_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= b0_vld_reg;
        end
        if (en) begin
            b1_near_reg <= b0_near_reg;
            b1_x_reg    <= ROT_W'(mx >>> 14);
            b1_y_reg    <= ROT_W'(my >>> 14);
            b1_z_reg    <= b0_z_reg;
        end
    end

    // ---- rotation CORDIC, one micro-rotation per stage
    logic                    r_vld_reg  [N];
    logic                    r_near_reg [N];
    logic signed [ROT_W-1:0] r_x_reg    [N];
    logic signed [ROT_W-1:0] r_y_reg    [N];
    logic [AW-1:0]           r_z_reg    [N];

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic [31:0] ATAN_FULL = atan_step(i, AW);
        logic                    vld_in, near_in;
        logic signed [ROT_W-1:0] x_in, y_in, x_next, y_next;
        logic [AW-1:0]           z_in_s, z_next;

        if (i == 0) begin : g_first
            assign vld_in  = b1_vld_reg;
            assign near_in = b1_near_reg;
            assign x_in    = b1_x_reg;
            assign y_in    = b1_y_reg;
            assign z_in_s  = b1_z_reg;
        end else begin : g_next
            assign vld_in  = r_vld_reg[i-1];
            assign near_in = r_near_reg[i-1];
            assign x_in    = r_x_reg[i-1];
            assign y_in    = r_y_reg[i-1];
            assign z_in_s  = r_z_reg[i-1];
        end

        // drive the residual angle toward zero
        always_comb begin
            if (!z_in_s[AW-1]) begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in_s - ATAN_FULL[AW-1:0];
            end else begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in_s + ATAN_FULL[AW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_vld_reg[i] <= 1'b0;
            end else if (en) begin
                r_vld_reg[i] <= vld_in;
            end
            if (en) begin
                r_near_reg[i] <= near_in;
                r_x_reg[i]    <= x_next;
                r_y_reg[i]    <= y_next;
                r_z_reg[i]    <= z_next;
            end
        end
    end

    // ---- round to integer and saturate
    logic signed [ROT_W-1:0] xr, yr;
    logic signed [QW-1:0]    xq, yq;
    assign xr = r_x_reg[N-1] + ROT_W'(32768);
    assign yr = r_y_reg[N-1] + ROT_W'(32768);
    assign xq = xr[ROT_W-1:16];
    assign yq = yr[ROT_W-1:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= r_vld_reg[N-1];
        end
        if (en) begin
            out_near <= r_near_reg[N-1];
            out_fwd  <= (xq > SAT_HI) ? OUT_W'(SAT_HI) :
                        ((xq < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(xq));
            out_lat  <= (yq > SAT_HI) ? OUT_W'(SAT_HI) :
                        ((yq < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(yq));
        end
    end

    assign out_valid = out_vld_reg;

endmodule

[hdl/body_frame_target_velocity_unit.sv]
`timescale 1ns / 1ps
// Top level of the body frame target velocity block: stream ports and settings registers.
// Depends on bftv_pkg, bftv_front, bftv_queue and bftv_back.

// Each input word carries the robot position, the next waypoint and the heading
// as a binary angle; each output word carries the velocity command toward that
// waypoint in the robot frame, lateral component first, forward second, with
// tuser high when the proportional near-waypoint rule applied instead of the
// fixed far speed. The block takes one word per clock when the output side keeps
// up: a front pipeline of 2 + N stages (offset, exact near test, gain, vectoring
// CORDIC for the bearing) feeds a four-entry queue, and a back pipeline of 3 + N
// stages (quadrant fold, 1/K scale multiplier, rotation CORDIC, round and
// saturate) drains it, N being min(CORDIC_STEPS, 24). Either side may stall alone: the queue
// absorbs short output stalls while the front keeps accepting. Settings are written
// through the cfg port (index 0 near radius, 1 near gain, 2 max speed; other
// indexes are ignored) and must only change while nothing is in flight.
module body_frame_target_velocity_unit
    import bftv_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int S_TDATA_W    = ((4 * COORD_WIDTH + HEADING_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // robot_x, robot_y, goal_x, goal_y (COORD_WIDTH each), heading (16), zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_first [15:0], drive_second [31:16]
    output logic [2*OUT_W-1:0]    m_tdata,
    // near_mode
    output logic                  m_tuser,
    // settings write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int QDW = 2 * VEC_W + ANGLE_WIDTH + 1;

    // ---- settings registers; writes are always taken
    logic [RADIUS_W-1:0] near_radius_reg;
    logic [GAIN_W-1:0]   near_gain_reg;
    logic [SPEED_W-1:0]  max_speed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_radius_reg <= RADIUS_RESET;
            near_gain_reg   <= GAIN_RESET;
            max_speed_reg   <= SPEED_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NEAR_RADIUS: near_radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_NEAR_GAIN:   near_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:   max_speed_reg   <= cfg_data[SPEED_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ---- front: classify the word and find the bearing
    logic                    f_valid, f_ready, f_near;
    logic signed [VEC_W-1:0] f_vx, f_vy;
    logic [ANGLE_WIDTH-1:0]  f_phi;

    bftv_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .robot_x     (s_tdata[CW-1:0]),
        .robot_y     (s_tdata[2*CW-1:CW]),
        .goal_x      (s_tdata[3*CW-1:2*CW]),
        .goal_y      (s_tdata[4*CW-1:3*CW]),
        .heading     (s_tdata[4*CW+HEADING_W-1:4*CW]),
        .near_radius (near_radius_reg),
        .near_gain   (near_gain_reg),
        .max_speed   (max_speed_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_vx      (f_vx),
        .out_vy      (f_vy),
        .out_phi     (f_phi),
        .out_near    (f_near)
    );

    // ---- queue between the two halves
    logic           q_valid, q_ready;
    logic [QDW-1:0] q_data;

    bftv_queue #(
        .WIDTH (QDW),
        .DEPTH (4)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_near, f_phi, f_vy, f_vx}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // ---- back: rotate into the robot frame
    logic signed [OUT_W-1:0] lat, fwd;

    bftv_back #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_vx     (q_data[VEC_W-1:0]),
        .in_vy     (q_data[2*VEC_W-1:VEC_W]),
        .in_phi    (q_data[2*VEC_W+ANGLE_WIDTH-1:2*VEC_W]),
        .in_near   (q_data[QDW-1]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_lat   (lat),
        .out_fwd   (fwd),
        .out_near  (m_tuser)
    );

    assign m_tdata = {fwd, lat};

endmodule
